[hdl/baseline_dip_trigger_counter_macros.svh]
// Assertion shorthands used by the checker of this block.
`ifndef BASELINE_DIP_TRIGGER_COUNTER_MACROS_SVH
`define BASELINE_DIP_TRIGGER_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BDTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BDTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bdtc_pkg.sv]
package bdtc_pkg;

  localparam int NCH       = 3;
  localparam int BLOCK_LEN = 10;
  localparam int FIRE_AT   = 4;

  localparam int TIME_W    = 32;
  localparam int SAMPLE_W  = 10;
  localparam int DECLINE_W = 10;
  localparam int HOLDOFF_W = 15;
  localparam int TALLY_W   = 3;

  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SUM_W      = $clog2(BLOCK_LEN * SAMPLE_MAX + 1);
  localparam int IDX_W      = $clog2(BLOCK_LEN);
  localparam int CNT_W      = (FIRE_AT > 1) ? $clog2(FIRE_AT) : 1;
  localparam int INC_W      = $clog2(FIRE_AT + 1);

  localparam logic [DECLINE_W-1:0] DECLINE_RESET = DECLINE_W'(50);
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = HOLDOFF_W'(500);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = HOLDOFF_W;

  localparam logic [CFG_IDX_W-1:0] REG_DECLINE_CH0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINE_CH1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINE_CH2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_CH0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_CH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_CH2 = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
  } in_item_t;

  typedef struct packed {
    logic               hit_ch0;
    logic               hit_ch1;
    logic               hit_ch2;
    logic [TALLY_W-1:0] tally_ch0;
    logic [TALLY_W-1:0] tally_ch1;
    logic [TALLY_W-1:0] tally_ch2;
    logic               fire_ch0;
    logic               fire_ch1;
    logic               fire_ch2;
  } out_item_t;

  // What one channel lane found for the current transfer.
  typedef struct packed {
    logic               hit;
    logic [TALLY_W-1:0] tally;
    logic               fire;
  } lane_res_t;

endpackage

[hdl/bdtc_seq.sv]
module bdtc_seq
  import bdtc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  output logic block_end
);

  logic [IDX_W-1:0] sample_index;

  assign block_end = (sample_index == IDX_W'(BLOCK_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (accept) begin
      sample_index <= block_end ? '0 : sample_index + 1'b1;
    end
  end

endmodule

[hdl/bdtc_lane.sv]
module bdtc_lane
  import bdtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 block_end,
  input  logic [TIME_W-1:0]    now_ms,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [DECLINE_W-1:0] decline,
  input  logic [HOLDOFF_W-1:0] holdoff,
  output lane_res_t            res
);

  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  baseline_sum;
  logic [TIME_W-1:0] next_allowed;
  logic [CNT_W-1:0]  hit_count;

  logic [SUM_W:0]    sample_scaled;
  logic [SUM_W:0]    decline_scaled;
  logic              dip;
  logic              hit;
  logic [INC_W-1:0]  count_inc;
  logic              fire;
  logic [SUM_W-1:0]  running_sum_next;

  // sample*N < baseline - N*decline, rearranged so nothing goes negative
  assign sample_scaled  = (SUM_W + 1)'(sample) * (SUM_W + 1)'(BLOCK_LEN);
  assign decline_scaled = (SUM_W + 1)'(decline) * (SUM_W + 1)'(BLOCK_LEN);
  assign dip = (sample_scaled + decline_scaled) < {1'b0, baseline_sum};
  assign hit = dip && (now_ms > next_allowed);

  assign count_inc = INC_W'(hit_count) + 1'b1;
  assign fire      = hit && (count_inc == INC_W'(FIRE_AT));

  assign res.hit   = hit;
  assign res.tally = hit ? TALLY_W'(count_inc) : '0;
  assign res.fire  = fire;

  assign running_sum_next = running_sum + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      baseline_sum <= '0;
      next_allowed <= '0;
      hit_count    <= '0;
    end else if (accept) begin
      if (block_end) begin
        baseline_sum <= running_sum_next;
        running_sum  <= '0;
      end else begin
        running_sum  <= running_sum_next;
      end
      if (hit) begin
        next_allowed <= next_allowed + TIME_W'(holdoff);
        hit_count    <= fire ? '0 : CNT_W'(count_inc);
      end
    end
  end

endmodule

[hdl/bdtc_merge.sv]
module bdtc_merge
  import bdtc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  output logic                accept,
  input  lane_res_t [NCH-1:0] lane_res,
  output logic                result_valid,
  input  logic                result_stall,
  output out_item_t           result_item
);

  // Take a new transfer whenever the output register is empty or drains now.
  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_item.hit_ch0   <= lane_res[0].hit;
      result_item.hit_ch1   <= lane_res[1].hit;
      result_item.hit_ch2   <= lane_res[2].hit;
      result_item.tally_ch0 <= lane_res[0].tally;
      result_item.tally_ch1 <= lane_res[1].tally;
      result_item.tally_ch2 <= lane_res[2].tally;
      result_item.fire_ch0  <= lane_res[0].fire;
      result_item.fire_ch1  <= lane_res[1].fire;
      result_item.fire_ch2  <= lane_res[2].fire;
    end
  end

endmodule

[hdl/baseline_dip_trigger_counter.sv]
// Channel  | Direction | Handshake               | Payload
// sample   | in        | sample_valid/stall      | in_item_t: now_ms, three samples
// result   | out       | result_valid/stall      | out_item_t: hit, tally, fire per channel
// config   | in        | cfg_we                  | cfg_index, cfg_data
//
// Takes one transfer per clock while the result side does not stall; the result shows in the cycle after the transfer.
// All three channel lanes work in the cycle of the transfer, the output register merges them.
// Synchronous active-high rst clears all sums, times, counts and restores config.
// A stalled result holds the output register and stalls the sample side with it.
module baseline_dip_trigger_counter
  import bdtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  in_item_t              sample_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_item_t             result_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DECLINE_W-1:0] decline [NCH];
  logic [HOLDOFF_W-1:0] holdoff [NCH];
  logic [SAMPLE_W-1:0]  sample_vec [NCH];
  lane_res_t [NCH-1:0]  lane_res;
  logic                 accept;
  logic                 block_end;

  assign sample_vec[0] = sample_item.sample_ch0;
  assign sample_vec[1] = sample_item.sample_ch1;
  assign sample_vec[2] = sample_item.sample_ch2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        decline[c] <= DECLINE_RESET;
        holdoff[c] <= HOLDOFF_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECLINE_CH0: decline[0] <= cfg_data[DECLINE_W-1:0];
        REG_DECLINE_CH1: decline[1] <= cfg_data[DECLINE_W-1:0];
        REG_DECLINE_CH2: decline[2] <= cfg_data[DECLINE_W-1:0];
        REG_HOLDOFF_CH0: holdoff[0] <= cfg_data[HOLDOFF_W-1:0];
        REG_HOLDOFF_CH1: holdoff[1] <= cfg_data[HOLDOFF_W-1:0];
        REG_HOLDOFF_CH2: holdoff[2] <= cfg_data[HOLDOFF_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  bdtc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .block_end (block_end)
  );

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    bdtc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .block_end (block_end),
      .now_ms    (sample_item.now_ms),
      .sample    (sample_vec[c]),
      .decline   (decline[c]),
      .holdoff   (holdoff[c]),
      .res       (lane_res[c])
    );
  end

  bdtc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .accept       (accept),
    .lane_res     (lane_res),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

[hdl/bdtc_checker.sv]
`include "baseline_dip_trigger_counter_macros.svh"

module bdtc_checker
  import bdtc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      sample_valid,
  input logic      sample_stall,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result_item
);

  logic sample_xfer;
  logic result_xfer;

  assign sample_xfer = sample_valid && !sample_stall;
  assign result_xfer = result_valid && !result_stall;

  `BDTC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_item), "stalled result changed")

  `BDTC_ASSERT_NEXT(a_sample_to_result, sample_xfer, result_valid, "transfer gave no result")

  `BDTC_ASSERT_NEXT(a_no_invented, result_xfer && !sample_xfer, !result_valid, "result appeared without a transfer")

  `BDTC_ASSERT_NOW(a_fire_count, result_valid && (result_item.fire_ch0 || result_item.fire_ch1 || result_item.fire_ch2), (!result_item.fire_ch0 || (result_item.hit_ch0 && result_item.tally_ch0 == TALLY_W'(FIRE_AT))) && (!result_item.fire_ch1 || (result_item.hit_ch1 && result_item.tally_ch1 == TALLY_W'(FIRE_AT))) && (!result_item.fire_ch2 || (result_item.hit_ch2 && result_item.tally_ch2 == TALLY_W'(FIRE_AT))), "fire without a full count")

  `BDTC_ASSERT_NOW(a_idle_lane, result_valid, (result_item.hit_ch0 || (result_item.tally_ch0 == '0 && !result_item.fire_ch0)) && (result_item.hit_ch1 || (result_item.tally_ch1 == '0 && !result_item.fire_ch1)) && (result_item.hit_ch2 || (result_item.tally_ch2 == '0 && !result_item.fire_ch2)), "count or fire without a hit")

endmodule

bind baseline_dip_trigger_counter bdtc_checker u_bdtc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
